// ===== hw/rtl/tbci_pkg.sv =====
package tbci_pkg;

  localparam int NumRegs = 6;
  localparam logic [2:0] RegVertexOne  = 3'd0;
  localparam logic [2:0] RegVertexTwo  = 3'd1;
  localparam logic [2:0] RegVertexThree = 3'd2;
  localparam logic [2:0] RegColorOne   = 3'd3;

  localparam int NumEdges  = 3;
  localparam int NumChans  = 4;
  localparam int DivStages = 4;
  localparam int EdgeDepth = 3;
  localparam int ChanDepth = DivStages + 4;
  localparam int PipeDepth = EdgeDepth + ChanDepth;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int ProdW  = 34;
  localparam int EdgeW  = 35;
  localparam int WProdW = 44;
  localparam int NumW   = 46;
  localparam int RemW   = 43;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [DiffW-1:0]  bdx;
    logic signed [DiffW-1:0]  bdy;
  } edge_cfg_t;

endpackage

// ===== hw/rtl/tbci_point_if.sv =====
interface tbci_point_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_x;
  logic [15:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

// ===== hw/rtl/tbci_pixel_if.sv =====
interface tbci_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       degenerate;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output degenerate, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input degenerate, output ready);
endinterface

// ===== hw/rtl/tbci_edge_unit.sv =====
module tbci_edge_unit
  import tbci_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  input  edge_cfg_t               edge_cfg_i [NumEdges],
  output logic signed [EdgeW-1:0] edge_o [NumEdges]
);

  logic signed [DiffW-1:0] dx_q [NumEdges];
  logic signed [DiffW-1:0] dy_q [NumEdges];
  logic signed [ProdW-1:0] m1_q [NumEdges];
  logic signed [ProdW-1:0] m2_q [NumEdges];
  logic signed [EdgeW-1:0] e_q  [NumEdges];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NumEdges; i++) begin
        dx_q[i] <= DiffW'(px_i) - DiffW'(edge_cfg_i[i].ax);
        dy_q[i] <= DiffW'(py_i) - DiffW'(edge_cfg_i[i].ay);
        m1_q[i] <= dx_q[i] * edge_cfg_i[i].bdy;
        m2_q[i] <= dy_q[i] * edge_cfg_i[i].bdx;
        e_q[i]  <= EdgeW'(m1_q[i]) - EdgeW'(m2_q[i]);
      end
    end
  end

  assign edge_o = e_q;

endmodule

// ===== hw/rtl/tbci_chan_unit.sv =====
module tbci_chan_unit
  import tbci_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [EdgeW-1:0] edge_i [NumEdges],
  input  logic [7:0]              color_i [NumEdges],
  input  logic [EdgeW-1:0]        div_i,
  input  logic                    div_neg_i,
  output logic [7:0]              byte_o
);

  logic signed [WProdW-1:0] p_q [NumEdges];
  logic signed [NumW-1:0]   num_q;
  logic [NumW-1:0]          mag_q;
  logic                     neg_q;
  logic [RemW-1:0]          r_q   [DivStages+1];
  logic [7:0]               qt_q  [DivStages+1];
  logic                     ovf_q [DivStages+1];
  logic                     sgn_q [DivStages+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NumEdges; i++) begin
        p_q[i] <= $signed({1'b0, color_i[i]}) * edge_i[i];
      end
      num_q <= NumW'(p_q[0]) + NumW'(p_q[1]) + NumW'(p_q[2]);
      neg_q <= num_q[NumW-1] ^ div_neg_i;
      mag_q <= num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
      ovf_q[0] <= mag_q >= {3'b0, div_i, 8'b0};
      r_q[0]   <= mag_q[RemW-1:0];
      qt_q[0]  <= 8'd0;
      sgn_q[0] <= neg_q;
    end
  end

  for (genvar j = 1; j <= DivStages; j++) begin : g_div
    localparam int KHi = 9 - 2 * j;
    logic [RemW-1:0] ta, tb, ra, rb;
    logic [7:0]      qa, qb;

    always_comb begin
      ta = RemW'(div_i) << KHi;
      tb = RemW'(div_i) << (KHi - 1);
      ra = r_q[j-1];
      qa = qt_q[j-1];
      if (ra >= ta) begin
        ra = ra - ta;
        qa[KHi] = 1'b1;
      end
      rb = ra;
      qb = qa;
      if (rb >= tb) begin
        rb = rb - tb;
        qb[KHi-1] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= rb;
        qt_q[j]  <= qb;
        ovf_q[j] <= ovf_q[j-1];
        sgn_q[j] <= sgn_q[j-1];
      end
    end
  end

  assign byte_o = sgn_q[DivStages] ? 8'd0 :
                  ovf_q[DivStages] ? 8'hFF : qt_q[DivStages];

endmodule

// ===== hw/rtl/triangle_barycentric_color_interp_top.sv =====
// A point passes the edge unit, then the channel unit, to pixel valid.
// Throughput: one point per cycle; a stalled output freezes the whole pipe.
// Setup registers: edge terms; area difference, product, value and sign.
// Reset (rst_ni low, async) clears config, setup and all valid bits.
module triangle_barycentric_color_interp_top
  import tbci_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  tbci_point_if.sink   point_i,
  tbci_pixel_if.source pixel_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  logic [31:0] cfg_q [NumRegs];
  logic signed [CoordW-1:0] vx [NumEdges];
  logic signed [CoordW-1:0] vy [NumEdges];
  edge_cfg_t edge_d [NumEdges];
  edge_cfg_t edge_q [NumEdges];
  logic signed [DiffW-1:0] d31x_q, d31y_q;
  logic signed [ProdW-1:0] ma_q, mb_q;
  logic signed [EdgeW-1:0] area_q;
  logic [EdgeW-1:0] area_abs_q;
  logic area_neg_q, area_zero_q;
  logic [PipeDepth-1:0] vld_q;
  logic en;
  logic signed [EdgeW-1:0] edge_val [NumEdges];
  logic [7:0] chan [NumChans];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i && (int'(cfg_idx_i) < NumRegs)) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NumEdges; i++) begin
      vx[i] = cfg_q[i][15:0];
      vy[i] = cfg_q[i][31:16];
    end
    for (int i = 0; i < NumEdges; i++) begin
      edge_d[i].ax  = vx[(i+1)%NumEdges];
      edge_d[i].ay  = vy[(i+1)%NumEdges];
      edge_d[i].bdx = DiffW'(vx[(i+2)%NumEdges]) - DiffW'(vx[(i+1)%NumEdges]);
      edge_d[i].bdy = DiffW'(vy[(i+2)%NumEdges]) - DiffW'(vy[(i+1)%NumEdges]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEdges; i++) edge_q[i] <= '0;
      d31x_q      <= '0;
      d31y_q      <= '0;
      ma_q        <= '0;
      mb_q        <= '0;
      area_q      <= '0;
      area_abs_q  <= '0;
      area_neg_q  <= 1'b0;
      area_zero_q <= 1'b1;
    end else begin
      edge_q      <= edge_d;
      d31x_q      <= DiffW'(vx[2]) - DiffW'(vx[0]);
      d31y_q      <= DiffW'(vy[2]) - DiffW'(vy[0]);
      ma_q        <= d31x_q * edge_q[2].bdy;
      mb_q        <= d31y_q * edge_q[2].bdx;
      area_q      <= EdgeW'(ma_q) - EdgeW'(mb_q);
      area_abs_q  <= area_q[EdgeW-1] ? EdgeW'(-area_q) : EdgeW'(area_q);
      area_neg_q  <= area_q[EdgeW-1];
      area_zero_q <= area_q == '0;
    end
  end

  assign en = !vld_q[PipeDepth-1] || pixel_o.ready;
  assign point_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], point_i.valid};
    end
  end

  tbci_edge_unit u_edge (
    .clk_i      (clk_i),
    .en_i       (en),
    .px_i       (point_i.point_x),
    .py_i       (point_i.point_y),
    .edge_cfg_i (edge_q),
    .edge_o     (edge_val)
  );

  for (genvar k = 0; k < NumChans; k++) begin : g_chan
    logic [7:0] col [NumEdges];
    always_comb begin
      for (int i = 0; i < NumEdges; i++) col[i] = cfg_q[int'(RegColorOne) + i][8*k +: 8];
    end
    tbci_chan_unit u_chan (
      .clk_i     (clk_i),
      .en_i      (en),
      .edge_i    (edge_val),
      .color_i   (col),
      .div_i     (area_abs_q),
      .div_neg_i (area_neg_q),
      .byte_o    (chan[k])
    );
  end

  assign pixel_o.valid      = vld_q[PipeDepth-1];
  assign pixel_o.red        = area_zero_q ? 8'd0 : chan[0];
  assign pixel_o.green      = area_zero_q ? 8'd0 : chan[1];
  assign pixel_o.blue       = area_zero_q ? 8'd0 : chan[2];
  assign pixel_o.alpha      = area_zero_q ? 8'd0 : chan[3];
  assign pixel_o.degenerate = area_zero_q;

endmodule
